// ===== sv/maximal_munch_tokenizer_defines.svh =====
// Assertion macros for the maximal munch tokenizer.
// Needs aclk and aresetn in the scope where the macros are used.
`ifndef MAXIMAL_MUNCH_TOKENIZER_DEFINES_SVH
`define MAXIMAL_MUNCH_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MMT_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/mmt_pkg.sv =====
// Types, codes and character constants for the maximal munch tokenizer.
// No dependencies.
package mmt_pkg;

    localparam int POS_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH      = 4;
    localparam int MAX_RESULTS      = 3;

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_INT   = 4'd1,
        M_DOT   = 4'd2,
        M_FLOAT = 4'd3,
        M_WS    = 4'd4,
        M_I     = 4'd5,
        M_F     = 4'd6,
        M_FO    = 4'd7,
        M_ERR   = 4'd8
    } mode_t;

    typedef enum logic [3:0] {
        K_INT    = 4'd0,
        K_FLOAT  = 4'd1,
        K_SEMI   = 4'd2,
        K_IF     = 4'd3,
        K_FOR    = 4'd4,
        K_LPAREN = 4'd5,
        K_RPAREN = 4'd6,
        K_LBRACE = 4'd7,
        K_RBRACE = 4'd8,
        K_END    = 4'd9,
        K_ERROR  = 4'd10
    } kind_t;

    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_F      = 8'h66;
    localparam logic [7:0] CH_O      = 8'h6F;
    localparam logic [7:0] CH_R      = 8'h72;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] start;
        logic [31:0] len;
        logic        last;
    } result_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
    endfunction

endpackage

// ===== sv/maximal_munch_tokenizer.sv =====
// Maximal munch tokenizer: scan state, per-character token logic and result queue.
// Depends on mmt_pkg and maximal_munch_tokenizer_defines.svh.
//
// One byte of text per transaction on the s_ side, one token per transaction on
// the m_ side. The scan state updates in the cycle a character is accepted, so a
// new character can be taken every cycle that s_tready is high. A character yields
// zero to three tokens, which enter a four-entry result queue; s_tready is high while
// the queue holds at most one token, so with m_tready high a stream of one token or
// less per character runs at one character per cycle; a character that yields two or
// three tokens holds s_tready low until the queue is back to one token. Positions and
// lengths count in POS_BITS bits, saturate, and are reported in their low 32 bits.
`include "maximal_munch_tokenizer_defines.svh"

module maximal_munch_tokenizer #(
    parameter int POS_BITS = mmt_pkg::POS_BITS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    input  logic [0:0]  s_tuser,   // [0] char_present
    input  logic        s_tlast,   // ends_text
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] start_pos, [63:32] token_length
    output logic [3:0]  m_tuser,   // [3:0] token_kind
    output logic        m_tlast    // last_of_run
);
    import mmt_pkg::*;

    localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    mode_t               mode_reg, mode_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] tstart_reg, tstart_next;
    logic [POS_BITS-1:0] tlen_reg, tlen_next;

    result_t              queue_reg [QUEUE_DEPTH];
    result_t              queue_next [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] head_reg, head_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;

    result_t    res [MAX_RESULTS];
    logic [1:0] res_n;
    logic       s_acc, m_acc, taken;
    logic [7:0] c;

    function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + POS_BITS'(1);
    endfunction

    assign c        = s_tdata;
    assign s_tready = (count_reg < QCNT_BITS'(QUEUE_DEPTH - MAX_RESULTS + 1));
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = m_tvalid && m_tready;

    always_comb begin
        mode_next   = mode_reg;
        pos_next    = pos_reg;
        tstart_next = tstart_reg;
        tlen_next   = tlen_reg;
        taken       = 1'b1;
        res_n       = '0;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i] = '{kind: K_END, start: '0, len: '0, last: 1'b0};
        end

        if (s_tuser[0] && (mode_next != M_ERR)) begin
            unique case (mode_next)
                M_INT: begin
                    if (is_digit(c)) begin
                        tlen_next = sat_inc(tlen_next);
                    end else if (c == CH_DOT) begin
                        tlen_next = sat_inc(tlen_next);
                        mode_next = M_FLOAT;
                    end else begin
                        taken = 1'b0;
                    end
                end
                M_DOT, M_FLOAT: begin
                    if (is_digit(c)) begin
                        tlen_next = sat_inc(tlen_next);
                        mode_next = M_FLOAT;
                    end else begin
                        taken = 1'b0;
                    end
                end
                M_WS: begin
                    if (is_space(c)) tlen_next = sat_inc(tlen_next);
                    else taken = 1'b0;
                end
                M_I: begin
                    if (c == CH_F) begin
                        res[res_n] = '{K_IF, 32'(tstart_next), 32'd2, 1'b0};
                        res_n      = res_n + 2'd1;
                        mode_next  = M_IDLE;
                    end else begin
                        taken = 1'b0;
                    end
                end
                M_F: begin
                    if (c == CH_O) begin
                        tlen_next = POS_BITS'(2);
                        mode_next = M_FO;
                    end else begin
                        taken = 1'b0;
                    end
                end
                M_FO: begin
                    if (c == CH_R) begin
                        res[res_n] = '{K_FOR, 32'(tstart_next), 32'd3, 1'b0};
                        res_n      = res_n + 2'd1;
                        mode_next  = M_IDLE;
                    end else begin
                        taken = 1'b0;
                    end
                end
                default: taken = 1'b0;
            endcase

            if (!taken) begin
                // close the open token
                case (mode_next)
                    M_INT, M_FLOAT: begin
                        res[res_n] = '{(mode_next == M_INT) ? K_INT : K_FLOAT,
                                       32'(tstart_next), 32'(tlen_next), 1'b0};
                        res_n      = res_n + 2'd1;
                        mode_next  = M_IDLE;
                    end
                    M_DOT, M_I, M_F, M_FO: begin
                        res[res_n] = '{K_ERROR, 32'(tstart_next), 32'd0, 1'b0};
                        res_n      = res_n + 2'd1;
                        mode_next  = M_ERR;
                    end
                    M_WS:    mode_next = M_IDLE;
                    default: ;
                endcase
                // open a new token
                if (mode_next == M_IDLE) begin
                    tstart_next = pos_reg;
                    tlen_next   = POS_BITS'(1);
                    if (is_digit(c)) begin
                        mode_next = M_INT;
                    end else if (c == CH_DOT) begin
                        mode_next = M_DOT;
                    end else if (is_space(c)) begin
                        mode_next = M_WS;
                    end else if (c == CH_I) begin
                        mode_next = M_I;
                    end else if (c == CH_F) begin
                        mode_next = M_F;
                    end else begin
                        unique case (c)
                            CH_SEMI:   res[res_n] = '{K_SEMI, 32'(pos_reg), 32'd1, 1'b0};
                            CH_LPAREN: res[res_n] = '{K_LPAREN, 32'(pos_reg), 32'd1, 1'b0};
                            CH_RPAREN: res[res_n] = '{K_RPAREN, 32'(pos_reg), 32'd1, 1'b0};
                            CH_LBRACE: res[res_n] = '{K_LBRACE, 32'(pos_reg), 32'd1, 1'b0};
                            CH_RBRACE: res[res_n] = '{K_RBRACE, 32'(pos_reg), 32'd1, 1'b0};
                            default: begin
                                res[res_n] = '{K_ERROR, 32'(pos_reg), 32'd0, 1'b0};
                                mode_next  = M_ERR;
                            end
                        endcase
                        res_n = res_n + 2'd1;
                    end
                end
            end
        end
        if (s_tuser[0]) pos_next = sat_inc(pos_reg);

        if (s_tlast) begin
            if (mode_next != M_ERR) begin
                case (mode_next)
                    M_INT, M_FLOAT: begin
                        res[res_n] = '{(mode_next == M_INT) ? K_INT : K_FLOAT,
                                       32'(tstart_next), 32'(tlen_next), 1'b0};
                        res_n      = res_n + 2'd1;
                        mode_next  = M_IDLE;
                    end
                    M_DOT, M_I, M_F, M_FO: begin
                        res[res_n] = '{K_ERROR, 32'(tstart_next), 32'd0, 1'b0};
                        res_n      = res_n + 2'd1;
                        mode_next  = M_ERR;
                    end
                    default: ;
                endcase
                if (mode_next != M_ERR) begin
                    res[res_n] = '{K_END, 32'(pos_next), 32'd0, 1'b0};
                    res_n      = res_n + 2'd1;
                end
            end
            mode_next   = M_IDLE;
            pos_next    = '0;
            tstart_next = '0;
            tlen_next   = '0;
        end

        for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].last = (i == int'(res_n) - 1);
        end
    end

    always_comb begin
        queue_next = queue_reg;
        head_next  = head_reg;
        count_next = count_reg;
        if (m_acc) begin
            head_next  = head_reg + QPTR_BITS'(1);
            count_next = count_next - QCNT_BITS'(1);
        end
        if (s_acc) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                if (i < int'(res_n)) begin
                    queue_next[QPTR_BITS'(int'(head_reg) + int'(count_reg) + i)] = res[i];
                end
            end
            count_next = count_next + QCNT_BITS'(res_n);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg   <= M_IDLE;
            pos_reg    <= '0;
            tstart_reg <= '0;
            tlen_reg   <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
        end else begin
            if (s_acc) begin
                mode_reg   <= mode_next;
                pos_reg    <= pos_next;
                tstart_reg <= tstart_next;
                tlen_reg   <= tlen_next;
            end
            head_reg  <= head_next;
            count_reg <= count_next;
        end
        queue_reg <= queue_next;
    end

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = {queue_reg[head_reg].len, queue_reg[head_reg].start};
    assign m_tuser  = queue_reg[head_reg].kind;
    assign m_tlast  = queue_reg[head_reg].last;

    `MMT_ASSERT_SAME(a_queue_bound, 1'b1, count_reg <= QCNT_BITS'(QUEUE_DEPTH),
        "result queue overflow")
    `MMT_ASSERT_NEXT(a_end_resets, s_acc && s_tlast,
        mode_reg == M_IDLE && pos_reg == '0 && tlen_reg == '0,
        "scan state not cleared after end of text")
    `MMT_ASSERT_NEXT(a_pos_monotonic, s_acc && !s_tlast, pos_reg >= $past(pos_reg),
        "position moved backward within a text")

endmodule
